// ----- design/u8n1_pkg.sv -----
// Shared types and constants for the 8N1 UART transceiver.
package u8n1_pkg;

  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RESET = 16'd90;
  localparam logic [3:0] TX_STOP_IDX = 4'd9;
  localparam logic [3:0] TX_LAST_IDX = 4'd10;
  localparam logic [3:0] RX_LAST_IDX = 4'd8;

  typedef struct packed {
    logic       rx_line;
    logic       send_request;
    logic [7:0] send_data;
  } in_req_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_active;
    logic       rx_ready;
    logic [7:0] rx_data;
  } out_rsp_t;

  typedef struct packed {
    logic tx_line;
    logic tx_active;
  } tx_stat_t;

  typedef struct packed {
    logic       rx_ready;
    logic [7:0] rx_data;
  } rx_stat_t;

endpackage

// ----- design/u8n1_tx.sv -----
// Transmit framer: start bit, eight data bits LSB first, stop bit.
module u8n1_tx import u8n1_pkg::*; #(
  parameter int unsigned TW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          send_request,
  input  logic [7:0]    send_data,
  input  logic [TW-1:0] per,
  output tx_stat_t      stat
);

  logic [7:0]    shift_r, shift_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [TW:0]   cnt_inc;
  logic [3:0]    idx_inc;

  always_comb begin
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    cnt_inc   = {1'b0, cnt_r} + {{TW{1'b0}}, 1'b1};
    idx_inc   = idx_r + 4'd1;
    if (busy_r) begin
      if (cnt_inc >= {1'b0, per}) begin
        cnt_nxt = '0;
        idx_nxt = idx_inc;
        if (idx_inc >= TX_LAST_IDX) begin
          busy_nxt = 1'b0;
          idx_nxt  = '0;
        end
      end else begin
        cnt_nxt = cnt_inc[TW-1:0];
      end
    end else if (send_request) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      cnt_nxt   = '0;
      shift_nxt = send_data;
    end
  end

  always_comb begin
    stat.tx_active = busy_nxt;
    stat.tx_line   = 1'b1;
    if (busy_nxt) begin
      if (idx_nxt == '0) begin
        stat.tx_line = 1'b0;
      end else if (idx_nxt < TX_STOP_IDX) begin
        stat.tx_line = shift_nxt[3'(idx_nxt - 4'd1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else if (step) begin
      shift_r <= shift_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ----- design/u8n1_rx.sv -----
// Receive sampler: half-period align, eight samples, half-period tail.
module u8n1_rx import u8n1_pkg::*; #(
  parameter int unsigned TW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          rx_line,
  input  logic [TW-1:0] per,
  input  logic [TW-1:0] half,
  output rx_stat_t      stat
);

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_HALF,
    RX_DATA,
    RX_TAIL
  } rx_state_t;

  rx_state_t     state_r, state_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [TW:0]   cnt_inc;
  logic [3:0]    idx_inc;

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    stat.rx_ready = 1'b0;
    stat.rx_data  = '0;
    cnt_inc       = {1'b0, cnt_r} + {{TW{1'b0}}, 1'b1};
    idx_inc       = idx_r + 4'd1;
    case (state_r)
      RX_IDLE: begin
        if (!rx_line) begin
          state_nxt = RX_HALF;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          shift_nxt = '0;
        end
      end
      RX_HALF: begin
        cnt_nxt = cnt_inc[TW-1:0];
        if (cnt_inc >= {1'b0, half}) begin
          state_nxt = RX_DATA;
          cnt_nxt   = '0;
        end
      end
      RX_DATA: begin
        cnt_nxt = cnt_inc[TW-1:0];
        if (cnt_inc >= {1'b0, per}) begin
          cnt_nxt   = '0;
          shift_nxt = {rx_line, shift_r[7:1]};
          idx_nxt   = idx_inc;
          if (idx_inc >= RX_LAST_IDX) begin
            state_nxt = RX_TAIL;
            idx_nxt   = '0;
          end
        end
      end
      RX_TAIL: begin
        cnt_nxt = cnt_inc[TW-1:0];
        if (cnt_inc >= {1'b0, half}) begin
          stat.rx_ready = 1'b1;
          stat.rx_data  = shift_r;
          state_nxt     = RX_IDLE;
          cnt_nxt       = '0;
          idx_nxt       = '0;
        end
      end
      default: state_nxt = RX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RX_IDLE;
      shift_r <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      shift_r <= shift_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/uart_8n1_bit_timed_transceiver.sv -----
// Top level of the 8N1 UART transceiver: config register, tick datapath, result register.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_req  (in_req_t)
//   out     | output    | out_valid / out_stall | out_rsp (out_rsp_t)
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (bit period)
//
// One request per clock while in_stall is low; each accepted request is one tick
// and its result is in the result register on the next cycle. Only the result
// register stands between them. Synchronous reset sets bit period 90, both sides idle.
// A held result stalls the input only while out_stall is high.
module uart_8n1_bit_timed_transceiver import u8n1_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data
);

  localparam logic [32:0] PER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic [CFG_WIDTH-1:0]   bit_period_r;
  logic [32:0]            bp_ext;
  logic [32:0]            bp_clip;
  logic [TIMER_WIDTH-1:0] per;
  logic [TIMER_WIDTH-1:0] half;
  logic                   accept;
  tx_stat_t               tx_stat;
  rx_stat_t               rx_stat;
  logic                   out_valid_r;
  out_rsp_t               out_rsp_r;

  always_comb begin
    bp_ext  = 33'(bit_period_r);
    bp_clip = (bp_ext > PER_MAX) ? PER_MAX : bp_ext;
    per     = TIMER_WIDTH'(bp_clip);
    if (per == '0) begin
      per = TIMER_WIDTH'(1);
    end
    half = per >> 1;
    if (half == '0) begin
      half = TIMER_WIDTH'(1);
    end
  end

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      bit_period_r <= cfg_wr_data;
    end
  end

  u8n1_tx #(.TW(TIMER_WIDTH)) u_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .send_request (in_req.send_request),
    .send_data    (in_req.send_data),
    .per          (per),
    .stat         (tx_stat)
  );

  u8n1_rx #(.TW(TIMER_WIDTH)) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_line (in_req.rx_line),
    .per     (per),
    .half    (half),
    .stat    (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r.tx_line   <= tx_stat.tx_line;
      out_rsp_r.tx_active <= tx_stat.tx_active;
      out_rsp_r.rx_ready  <= rx_stat.rx_ready;
      out_rsp_r.rx_data   <= rx_stat.rx_data;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request left no result");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending result");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.tx_active) |-> out_rsp_r.tx_line)
    else $error("tx line low while transmitter idle");

  a_rx_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.rx_ready) |-> (out_rsp_r.rx_data == '0))
    else $error("rx data nonzero without rx ready");

endmodule
